@@ design/pvm_pkg.sv @@
// shared types, constants and helpers of the pcm voice mixer
package pvm_pkg;

  localparam int unsigned GROUP_SIZE = 8;
  localparam logic [16:0] UNITY = 17'h10000;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_VOICE  = 2'd1,
    KIND_BG     = 2'd2,
    KIND_RENDER = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        address;
    logic signed [15:0] sample_value;
    logic [16:0]        track_length;
    logic [16:0]        track_volume;
    logic               repeat_req;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_sample_0;
    logic signed [15:0] out_sample_1;
    logic signed [15:0] out_sample_2;
    logic signed [15:0] out_sample_3;
    logic signed [15:0] out_sample_4;
    logic signed [15:0] out_sample_5;
    logic signed [15:0] out_sample_6;
    logic signed [15:0] out_sample_7;
  } out_item_t;

  // one track table entry
  typedef struct packed {
    logic [15:0] start;
    logic [16:0] length;
    logic [16:0] pos;
    logic [16:0] gain;
    logic        loops;
  } track_t;

  // control from the sequencer to lanes and merge stage
  typedef struct packed {
    logic       rd;
    logic       mul;
    logic       clr;
    logic       add;
    logic [2:0] off;
  } mix_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BG_SEL,
    ST_RD_WAIT,
    ST_SQ,
    ST_CUBE,
    ST_CHK,
    ST_MOVE,
    ST_MUL,
    ST_ACC,
    ST_V_NEXT,
    ST_OUT
  } state_t;

  function automatic logic [16:0] clamp_gain(input logic [16:0] g);
    clamp_gain = (g > UNITY) ? UNITY : g;
  endfunction

endpackage

@@ design/pvm_table.sv @@
// track table memory with one write port and one registered read port
module pvm_table #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IW-1:0]     waddr,
  input  pvm_pkg::track_t   wdata,
  input  logic              re,
  input  logic [IW-1:0]     raddr,
  output pvm_pkg::track_t   rdata
);

  pvm_pkg::track_t mem [DEPTH];
  pvm_pkg::track_t rd_q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q_r <= mem[raddr];
    end
  end

  assign rdata = rd_q_r;

endmodule

@@ design/pvm_lane.sv @@
// one lane: a sample bank, its read register and a gain multiplier
module pvm_lane #(
  parameter int unsigned AW   = 16,
  parameter int unsigned LANE = 0
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-4:0]       wr_row,
  input  logic [15:0]         wr_data,
  input  pvm_pkg::mix_ctl_t   ctl,
  input  logic [AW-4:0]       base_row,
  input  logic [16:0]         cube,
  output logic [15:0]         prod
);

  localparam int unsigned ROWS = 2 ** (AW - 3);
  localparam logic [2:0] LANE_ID = 3'(LANE);

  logic [15:0]   bank [ROWS];
  logic [15:0]   word_r;
  logic [15:0]   prod_r;
  logic [AW-4:0] rd_row;
  logic          neg;
  logic [16:0]   mag;
  logic [33:0]   full;
  logic [15:0]   scaled;

  // this bank holds the element one row further on when it sits below the offset
  assign rd_row = base_row + ((LANE_ID < ctl.off) ? (AW-3)'(1) : (AW-3)'(0));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank[wr_row] <= wr_data;
    end
    if (ctl.rd) begin
      word_r <= bank[rd_row];
    end
  end

  always_comb begin
    neg    = word_r[15];
    mag    = neg ? (17'h10000 - {1'b0, word_r}) : {1'b0, word_r};
    full   = {17'd0, mag} * {17'd0, cube};
    scaled = full[31:16];
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= neg ? (16'd0 - scaled) : scaled;
    end
  end

  assign prod = prod_r;

endmodule

@@ design/pvm_merge.sv @@
// merge stage: rotates lane products into group order and accumulates
module pvm_merge (
  input  logic              clk,
  input  pvm_pkg::mix_ctl_t ctl,
  input  logic [15:0]       prod [8],
  output logic [15:0]       acc [8]
);

  logic [15:0] acc_r [8];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      if (ctl.clr) begin
        acc_r[k] <= 16'd0;
      end else if (ctl.add) begin
        acc_r[k] <= acc_r[k] + prod[3'(k) + ctl.off];
      end
    end
  end

  assign acc = acc_r;

endmodule

@@ design/pcm_voice_mixer_core.sv @@
// top level of the pcm voice mixer: sequencer, gain unit, lanes and tables
//
//   channel | ports                     | direction | handshake
//   --------+---------------------------+-----------+-----------------
//   input   | in_valid in_ready in_data | in        | valid / ready
//   result  | out_valid out_ready out_data | out    | valid / ready
//   config  | cfg_we cfg_wdata          | in        | write strobe
//
// write and add items are taken in the idle state; a render holds the input while it
// walks the current background group (played or ended), then every played, rewound or
// removed voice, through the one shared 17x17 gain multiplier and the registered table
// and bank reads
// reset (rst_n low, synchronous) empties both tables and the output register;
// the sample banks are not cleared
// a finished group waits in the output register while new items are taken;
// a next render holds in its last state until that register frees
module pcm_voice_mixer_core #(
  parameter int unsigned MAX_VOICES   = 16,
  parameter int unsigned SAMPLE_DEPTH = 65536
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pvm_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pvm_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic [16:0]          cfg_wdata
);

  localparam int unsigned IW   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int unsigned CW   = $clog2(MAX_VOICES + 1);
  localparam int unsigned AW   = $clog2(SAMPLE_DEPTH);
  localparam int unsigned WAW  = (AW > 16) ? AW : 16;
  localparam int unsigned SUMW = (AW > 18) ? AW : 18;

  // control registers
  pvm_pkg::state_t state_r, state_nxt;
  logic            is_bg_r, is_bg_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [IW-1:0]   bgc_r, bgc_nxt;
  logic [IW-1:0]   bg_cur_r, bg_cur_nxt;
  logic [CW-1:0]   vcount_r, vcount_nxt;
  logic [CW-1:0]   bgcount_r, bgcount_nxt;
  logic [16:0]     gvol_r;
  logic            out_valid_r, out_valid_nxt;

  // datapath registers
  logic [16:0]     g_r, g_nxt;
  logic [16:0]     sq_r, sq_nxt;
  logic [16:0]     cube_r, cube_nxt;
  logic [2:0]      off_r, off_nxt;
  pvm_pkg::out_item_t out_r;
  logic            out_load;

  // table ports
  logic            v_we, v_re, b_we, b_re;
  logic [IW-1:0]   v_waddr, v_raddr, b_waddr, b_raddr;
  pvm_pkg::track_t v_wdata, b_wdata, v_rd, b_rd, ent, upd;

  // gain multiplier
  logic [16:0]     mul_a, mul_b;
  logic [33:0]     mul_p;

  // track positions
  logic [SUMW-1:0] base_sum;
  logic [AW-1:0]   base;
  logic            fits;
  logic [CW-1:0]   bg_inc;

  pvm_pkg::mix_ctl_t ctl;
  logic [15:0]     prod [8];
  logic [15:0]     acc [8];
  logic [AW-1:0]   wr_addr;
  logic            smp_we;

  logic            in_acc;
  pvm_pkg::track_t new_ent;

  assign in_ready = (state_r == pvm_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign new_ent = '{start: in_data.address, length: in_data.track_length, pos: 17'd0,
                     gain: in_data.track_volume, loops: in_data.repeat_req};

  pvm_table #(.DEPTH(MAX_VOICES), .IW(IW)) u_voice_tbl (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .re(v_re), .raddr(v_raddr), .rdata(v_rd)
  );

  pvm_table #(.DEPTH(MAX_VOICES), .IW(IW)) u_bg_tbl (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rd)
  );

  assign ent = is_bg_r ? b_rd : v_rd;

  // shared gain unit: product of two q1.16 values, truncated back to q1.16
  always_comb begin
    unique case (state_r)
      pvm_pkg::ST_SQ:   begin mul_a = g_r;  mul_b = g_r; end
      pvm_pkg::ST_CUBE: begin mul_a = sq_r; mul_b = g_r; end
      default: begin
        mul_a = pvm_pkg::clamp_gain(ent.gain);
        mul_b = is_bg_r ? pvm_pkg::clamp_gain(gvol_r) : pvm_pkg::UNITY;
      end
    endcase
    mul_p = {17'd0, mul_a} * {17'd0, mul_b};
  end

  // start of the group in the sample space, wrapped to the memory size
  always_comb begin
    base_sum = SUMW'(ent.start) + SUMW'(ent.pos);
    base     = base_sum[AW-1:0];
    fits     = ({1'b0, ent.pos} + 18'd8) <= {1'b0, ent.length};
    bg_inc   = CW'(bgc_r) + CW'(1);
  end

  // sample writes go to the bank picked by the low address bits
  assign wr_addr = AW'(WAW'(in_data.address));
  assign smp_we  = in_acc && (in_data.kind == pvm_pkg::KIND_WRITE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    is_bg_nxt     = is_bg_r;
    idx_nxt       = idx_r;
    bgc_nxt       = bgc_r;
    bg_cur_nxt    = bg_cur_r;
    vcount_nxt    = vcount_r;
    bgcount_nxt   = bgcount_r;
    g_nxt         = g_r;
    sq_nxt        = sq_r;
    cube_nxt      = cube_r;
    off_nxt       = off_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    v_we = 1'b0; v_waddr = idx_r[IW-1:0]; v_wdata = new_ent;
    v_re = 1'b0; v_raddr = idx_r[IW-1:0];
    b_we = 1'b0; b_waddr = bgcount_r[IW-1:0]; b_wdata = new_ent;
    b_re = 1'b0; b_raddr = bgc_r;
    ctl  = '{rd: 1'b0, mul: 1'b0, clr: 1'b0, add: 1'b0, off: off_r};
    upd  = ent;

    unique case (state_r)
      pvm_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data.kind)
            pvm_pkg::KIND_VOICE: begin
              if (vcount_r < CW'(MAX_VOICES)) begin
                v_we       = 1'b1;
                v_waddr    = vcount_r[IW-1:0];
                vcount_nxt = vcount_r + CW'(1);
              end
            end
            pvm_pkg::KIND_BG: begin
              if (bgcount_r < CW'(MAX_VOICES)) begin
                b_we        = 1'b1;
                bgcount_nxt = bgcount_r + CW'(1);
              end
            end
            pvm_pkg::KIND_RENDER: begin
              ctl.clr   = 1'b1;
              state_nxt = pvm_pkg::ST_BG_SEL;
            end
            default: begin
            end
          endcase
        end
      end

      // pick the current background track, falling back to the first
      pvm_pkg::ST_BG_SEL: begin
        if (bgcount_r == '0) begin
          idx_nxt   = '0;
          state_nxt = pvm_pkg::ST_V_NEXT;
        end else begin
          bgc_nxt   = (CW'(bg_cur_r) < bgcount_r) ? bg_cur_r : '0;
          b_re      = 1'b1;
          b_raddr   = (CW'(bg_cur_r) < bgcount_r) ? bg_cur_r : '0;
          is_bg_nxt = 1'b1;
          state_nxt = pvm_pkg::ST_RD_WAIT;
        end
      end

      // base gain: volume times master gain for background, volume alone for voices
      pvm_pkg::ST_RD_WAIT: begin
        g_nxt     = mul_p[32:16];
        state_nxt = pvm_pkg::ST_SQ;
      end

      pvm_pkg::ST_SQ: begin
        sq_nxt    = mul_p[32:16];
        state_nxt = pvm_pkg::ST_CUBE;
      end

      pvm_pkg::ST_CUBE: begin
        cube_nxt  = mul_p[32:16];
        state_nxt = pvm_pkg::ST_CHK;
      end

      pvm_pkg::ST_CHK: begin
        if (fits) begin
          // eight words left: read all banks and advance the position
          ctl.rd  = 1'b1;
          ctl.off = base[2:0];
          off_nxt = base[2:0];
          upd.pos = ent.pos + 17'd8;
          if (is_bg_r) begin
            b_we = 1'b1; b_waddr = bgc_r; b_wdata = upd;
          end else begin
            v_we = 1'b1; v_wdata = upd;
          end
          state_nxt = pvm_pkg::ST_MUL;
        end else if (is_bg_r) begin
          // background track ended: rewind it and move on in the playlist
          upd.pos    = 17'd0;
          b_we       = 1'b1; b_waddr = bgc_r; b_wdata = upd;
          bg_cur_nxt = (bg_inc >= bgcount_r) ? '0 : bg_inc[IW-1:0];
          idx_nxt    = '0;
          state_nxt  = pvm_pkg::ST_V_NEXT;
        end else if (ent.loops) begin
          upd.pos   = 17'd0;
          v_we      = 1'b1; v_wdata = upd;
          idx_nxt   = idx_r + CW'(1);
          state_nxt = pvm_pkg::ST_V_NEXT;
        end else begin
          // ended one-shot voice: fetch the last entry to fill its slot
          v_re      = 1'b1;
          v_raddr   = IW'(vcount_r - CW'(1));
          state_nxt = pvm_pkg::ST_MOVE;
        end
      end

      pvm_pkg::ST_MOVE: begin
        v_we       = 1'b1;
        v_wdata    = v_rd;
        vcount_nxt = vcount_r - CW'(1);
        state_nxt  = pvm_pkg::ST_V_NEXT;
      end

      pvm_pkg::ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = pvm_pkg::ST_ACC;
      end

      pvm_pkg::ST_ACC: begin
        ctl.add = 1'b1;
        if (is_bg_r) begin
          bg_cur_nxt = bgc_r;
          idx_nxt    = '0;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
        state_nxt = pvm_pkg::ST_V_NEXT;
      end

      pvm_pkg::ST_V_NEXT: begin
        is_bg_nxt = 1'b0;
        if (idx_r < vcount_r) begin
          v_re      = 1'b1;
          state_nxt = pvm_pkg::ST_RD_WAIT;
        end else begin
          state_nxt = pvm_pkg::ST_OUT;
        end
      end

      pvm_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = pvm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pvm_pkg::ST_IDLE;
      end
    endcase
  end

  // eight lanes, one per sample bank
  for (genvar j = 0; j < 8; j++) begin : g_lane
    pvm_lane #(.AW(AW), .LANE(j)) u_lane (
      .clk(clk),
      .wr_en(smp_we && (wr_addr[2:0] == 3'(j))),
      .wr_row(wr_addr[AW-1:3]),
      .wr_data(in_data.sample_value),
      .ctl(ctl),
      .base_row(base[AW-1:3]),
      .cube(cube_r),
      .prod(prod[j])
    );
  end

  pvm_merge u_merge (
    .clk(clk),
    .ctl(ctl),
    .prod(prod),
    .acc(acc)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pvm_pkg::ST_IDLE;
      is_bg_r     <= 1'b0;
      idx_r       <= '0;
      bgc_r       <= '0;
      bg_cur_r    <= '0;
      vcount_r    <= '0;
      bgcount_r   <= '0;
      gvol_r      <= pvm_pkg::UNITY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      is_bg_r     <= is_bg_nxt;
      idx_r       <= idx_nxt;
      bgc_r       <= bgc_nxt;
      bg_cur_r    <= bg_cur_nxt;
      vcount_r    <= vcount_nxt;
      bgcount_r   <= bgcount_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        gvol_r <= cfg_wdata;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    g_r    <= g_nxt;
    sq_r   <= sq_nxt;
    cube_r <= cube_nxt;
    off_r  <= off_nxt;
    if (out_load) begin
      out_r <= '{out_sample_0: acc[0], out_sample_1: acc[1], out_sample_2: acc[2],
                 out_sample_3: acc[3], out_sample_4: acc[4], out_sample_5: acc[5],
                 out_sample_6: acc[6], out_sample_7: acc[7]};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
